>>> src/cdt_pkg.sv
`timescale 1ns / 1ps

package cdt_pkg;

  // Field widths
  localparam int unsigned CfgW  = 11;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned DataW = 64;
  localparam int unsigned SmpW  = 10;

  // Defaults
  localparam int unsigned        TableDepthDef = 1024;
  localparam logic [CfgW-1:0]    TableSizeRst  = 11'd1024;

  // Input mode codes
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeDraw  = 1'b1;

  // Result word from the search unit
  typedef struct packed {
    logic                   valid;
    logic signed [SmpW-1:0] value;
  } cdt_res_t;

endpackage

>>> src/cdt_gaussian_sampler.sv
`timescale 1ns / 1ps

// Discrete Gaussian sampler by inversion of a cumulative distribution table.
// A word with mode_i low writes entry_value_i into the table at entry_index_i
// in the accept cycle and returns nothing; the block stays ready. A word with
// mode_i high draws one sample: a binary search over the table in use finds the
// last entry not above uniform_word_i and returns its index minus half the
// table size. The search runs on one registered table read port and one 64-bit
// compare, one halving step per cycle, so a draw holds the input stalled
// through every halving step and the hand-over of its sample, and longer
// while the output register still holds an earlier sample under stall. The
// sample enters the output register at the edge that ends the stall. The
// output register lets the next word enter while a sample waits. table_size
// must be written through cfg_we_i/cfg_wdata_i only while idle, which the
// block does not enforce; values below 2 act as 2 and values above the
// table depth act as the depth. Table entries hold no reset value, and
// entry zero is never read.
module cdt_gaussian_sampler import cdt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic [IdxW-1:0]        entry_index_i,
  input  logic [DataW-1:0]       entry_value_i,
  input  logic [DataW-1:0]       uniform_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [SmpW-1:0] sample_value_o
);

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned DepW  = $clog2(TableDepth + 1);
  localparam int unsigned SzW   = (DepW > CfgW) ? DepW : CfgW;
  localparam int unsigned WideW = IdxW + AddrW;

  logic [CfgW-1:0]        size_q;
  logic [SzW-1:0]         size_ext, size_eff;
  logic                   in_acc, draw_start, wr_en;
  logic [WideW-1:0]       widx;
  logic                   busy;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic [DataW-1:0]       rd_data;
  cdt_res_t               res;
  logic                   out_load;
  logic                   out_valid_q;
  logic signed [SmpW-1:0] out_q;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= TableSizeRst;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Clamp size to the table in use
  always_comb begin
    size_ext = SzW'(size_q);
    if (size_ext < SzW'(2)) begin
      size_eff = SzW'(2);
    end else if (size_ext > SzW'(TableDepth)) begin
      size_eff = SzW'(TableDepth);
    end else begin
      size_eff = size_ext;
    end
  end

  // Input handshake
  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;
  assign draw_start = in_acc && (mode_i == ModeDraw);
  assign widx       = WideW'(entry_index_i);
  assign wr_en      = in_acc && (mode_i == ModeWrite) && (widx < WideW'(TableDepth));

  cdt_table #(
    .Depth (TableDepth),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (widx[AddrW-1:0]),
    .wdata_i (entry_value_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  cdt_search #(
    .Depth (TableDepth),
    .AddrW (AddrW),
    .SzW   (SzW)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (draw_start),
    .word_i    (uniform_word_i),
    .size_i    (size_eff),
    .take_i    (out_load),
    .res_o     (res),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  // Output register: load when empty or draining
  assign out_load = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res.value;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_q;

  // A draw holds the input side until its sample is handed over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_start |=> in_stall_o)
    else $error("draw accepted without stalling the input");

  // A table write leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == ModeWrite) |=> !in_stall_o)
    else $error("table write made the block busy");

  // A new sample only appears after a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> in_stall_o)
    else $error("sample loaded while search idle");

  // Table reads only during a search or at its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (busy || draw_start))
    else $error("table read outside a search");

endmodule

>>> src/cdt_table.sv
`timescale 1ns / 1ps

module cdt_table import cdt_pkg::*; #(
  parameter int unsigned Depth = TableDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cdt_search.sv
`timescale 1ns / 1ps

module cdt_search import cdt_pkg::*; #(
  parameter int unsigned Depth = TableDepthDef,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned SzW   = CfgW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] word_i,
  input  logic [SzW-1:0]   size_i,
  input  logic             take_i,
  output cdt_res_t         res_o,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [DataW-1:0] rd_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSrch = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [SzW-1:0]         base_q, base_d;
  logic [SzW-1:0]         span_q, span_d;
  logic [SzW-1:0]         size_q;
  logic [DataW-1:0]       word_q;
  logic signed [SmpW-1:0] res_q, res_d;

  logic [SzW-1:0] half_cur, probe_cur, base_n, span_n, probe_n;
  logic           ge;

  // Step arithmetic: one compare, then the next probe
  always_comb begin
    half_cur  = span_q >> 1;
    probe_cur = base_q + half_cur;
    ge        = (word_q >= rd_data_i);
    base_n    = ge ? probe_cur : base_q;
    span_n    = ge ? (span_q - half_cur) : half_cur;
    probe_n   = base_n + (span_n >> 1);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    span_d    = span_q;
    res_d     = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = probe_n[AddrW-1:0];
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          base_d    = '0;
          span_d    = size_i;
          rd_en_o   = 1'b1;
          rd_addr_o = size_i[AddrW:1];
          state_d   = StSrch;
        end
      end
      StSrch: begin
        base_d = base_n;
        span_d = span_n;
        if (span_n > SzW'(1)) begin
          rd_en_o   = 1'b1;
          rd_addr_o = probe_n[AddrW-1:0];
        end else begin
          res_d   = SmpW'(base_n - (size_q >> 1));
          state_d = StDone;
        end
      end
      StDone: begin
        if (take_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    span_q <= span_d;
    res_q  <= res_d;
    if (start_i && state_q == StIdle) begin
      word_q <= word_i;
      size_q <= size_i;
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign res_o.valid = (state_q == StDone);
  assign res_o.value = res_q;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cdt_pkg::*;

  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned RandomItems    = 32;
  localparam int unsigned MaxReports     = 10;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   mode_i = ModeWrite;
  logic [IdxW-1:0]        entry_index_i = '0;
  logic [DataW-1:0]       entry_value_i = '0;
  logic [DataW-1:0]       uniform_word_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [SmpW-1:0] sample_value_o;

  // Shadow of the block state: table contents and size register
  logic [DataW-1:0]       cdf_copy [TableDepthDef];
  logic [CfgW-1:0]        size_cfg = TableSizeRst;
  logic signed [SmpW-1:0] pending_samples [$];

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_style = 0;
  int unsigned cycle_cnt = 0;

  cdt_gaussian_sampler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .uniform_word_i (uniform_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_value_o (sample_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [DataW-1:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // Clamp the size register the way the block does
  function automatic int unsigned eff_size();
    int unsigned sz;
    sz = size_cfg;
    if (sz < 2) sz = 2;
    if (sz > TableDepthDef) sz = TableDepthDef;
    return sz;
  endfunction

  // Find the last entry not above the word, down to one remaining entry
  function automatic logic signed [SmpW-1:0] predict_sample(logic [DataW-1:0] word);
    int unsigned sz;
    int unsigned base;
    int unsigned span;
    int unsigned half;
    logic [SmpW-1:0] diff;
    sz = eff_size();
    base = 0;
    span = sz;
    while (span > 1) begin
      half = span / 2;
      if (word >= cdf_copy[base + half]) begin
        base = base + half;
        span = span - half;
      end else begin
        span = half;
      end
    end
    diff = SmpW'(base - sz / 2);
    return $signed(diff);
  endfunction

  // Receiver: stall on a changing pattern, with stretches of no stall
  always @(negedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left = stall_left - 1;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= $urandom_range(0, 1);
      2: out_stall_i <= ($urandom_range(0, 4) != 0);
      default: out_stall_i <= ((cycle_cnt % 7) < 3);
    endcase
  end

  // Check each accepted sample against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        if (fail_cnt < MaxReports)
          $display("unexpected sample %0d at %0t", sample_value_o, $realtime);
        fail_cnt = fail_cnt + 1;
      end else begin
        if (sample_value_o !== pending_samples[0]) begin
          if (fail_cnt < MaxReports)
            $display("sample mismatch: expected %0d, got %0d at %0t",
                     pending_samples[0], sample_value_o, $realtime);
          fail_cnt = fail_cnt + 1;
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Send one word in bursts with random gaps; update the shadow on accept
  task automatic send_word(input logic mode, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] value, input logic [DataW-1:0] word);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left = burst_left - 1;
    mode_i = mode;
    entry_index_i = idx;
    entry_value_i = value;
    uniform_word_i = word;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent = items_sent + 1;
    if (mode == ModeWrite)
      cdf_copy[idx] = value;
    else
      pending_samples.push_back(predict_sample(word));
  endtask

  task automatic write_entry(input int unsigned idx, input logic [DataW-1:0] value);
    send_word(ModeWrite, IdxW'(idx), value, rand_word64());
  endtask

  task automatic draw(input logic [DataW-1:0] word);
    send_word(ModeDraw, IdxW'($urandom), rand_word64(), word);
  endtask

  // Drop valid, wait for every sample, then let the search pipeline drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_table_size(input logic [CfgW-1:0] value);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = CfgW'($urandom);
    size_cfg = value;
  endtask

  // Load entries 1..size-1: non-decreasing cumulative values, or raw noise
  task automatic load_table(input int unsigned size, input bit noisy);
    logic [DataW-1:0] step;
    logic [DataW-1:0] val;
    logic [DataW-1:0] pos;
    step = 64'hFFFF_FFFF_FFFF_FFFF / DataW'(size);
    for (int unsigned i = 1; i < size; i++) begin
      pos = DataW'(i);
      if (noisy)
        val = rand_word64();
      else if (i > 1 && $urandom_range(0, 7) == 0)
        val = cdf_copy[i - 1];
      else
        val = pos * step + rand_word64() % step;
      write_entry(i, val);
    end
  endtask

  // Pick a draw word: uniform, on or next to an entry, an extreme, or a random word shifted down
  function automatic logic [DataW-1:0] pick_word();
    int unsigned k;
    k = $urandom_range(1, eff_size() - 1);
    case ($urandom_range(0, 7))
      3: return cdf_copy[k];
      4: return cdf_copy[k] - 1;
      5: return cdf_copy[k] + 1;
      6: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      7: return rand_word64() >> $urandom_range(0, 63);
      default: return rand_word64();
    endcase
  endfunction

  // Fill the whole table under the reset size and draw across it
  task automatic test_reset_size_full_table();
    write_entry(0, '0);
    load_table(TableDepthDef, 1'b0);
    write_entry(TableDepthDef - 1, '1);
    draw('0);
    draw('1);
    draw(cdf_copy[512]);
    draw(cdf_copy[512] - 1);
    draw(cdf_copy[1]);
    draw(cdf_copy[1] - 1);
    repeat (10) draw(pick_word());
  endtask

  // Clamped sizes, the smallest tables, and entry zero never read
  task automatic test_size_limits();
    set_table_size(CfgW'(0));
    write_entry(0, '1);
    write_entry(1, 64'h8000_0000_0000_0000);
    draw('0);
    draw(64'h7FFF_FFFF_FFFF_FFFF);
    draw(64'h8000_0000_0000_0000);
    draw('1);
    set_table_size(CfgW'(1));
    draw(64'h8000_0000_0000_0000);
    set_table_size(CfgW'(2));
    draw(64'h7FFF_FFFF_FFFF_FFFF);
    set_table_size(CfgW'(3));
    write_entry(2, '1);
    draw('1);
    draw(64'hFFFF_FFFF_FFFF_FFFE);
    draw('0);
    set_table_size(CfgW'(2047));
    draw('1);
    draw('0);
    set_table_size(CfgW'(1023));
    draw('0);
    draw('1);
  endtask

  // Random phases: new size, maybe a small new table, then draws with stray writes
  task automatic test_random_phases();
    int unsigned start_items;
    int unsigned size;
    int unsigned sel;
    logic [CfgW-1:0] cfg_val;
    bit reload;
    start_items = items_sent;
    while (items_sent - start_items < RandomItems) begin
      sel = $urandom_range(0, 19);
      if (sel < 2)
        size = 2;
      else if (sel < 3)
        size = TableDepthDef;
      else if (sel < 15)
        size = $urandom_range(2, 40);
      else if (sel < 18)
        size = $urandom_range(41, 300);
      else
        size = $urandom_range(301, TableDepthDef);
      cfg_val = CfgW'(size);
      if (size == 2 && $urandom_range(0, 1) != 0)
        cfg_val = CfgW'($urandom_range(0, 1));
      if (size == TableDepthDef && $urandom_range(0, 1) != 0)
        cfg_val = CfgW'($urandom_range(TableDepthDef + 1, 2047));
      set_table_size(cfg_val);
      reload = (size <= 16) && ($urandom_range(0, 1) != 0);
      if (reload)
        load_table(size, $urandom_range(0, 7) == 0);
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 9) == 0)
          write_entry(($urandom_range(0, 1) != 0) ? $urandom_range(0, size - 1)
                                                  : $urandom_range(0, TableDepthDef - 1),
                      rand_word64());
        else
          draw(pick_word());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_size_full_table();
    test_size_limits();
    test_random_phases();
    wait_idle();
    if (fail_cnt == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
